>>> hw/rtl/trie_insert_and_walk_core_assert.svh
// Assertion macros for the prefix trie core.
// Depends on nothing; included by trie_insert_and_walk_core.sv, which checks its own logic.
`ifndef TRIE_INSERT_AND_WALK_CORE_ASSERT_SVH
`define TRIE_INSERT_AND_WALK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// expression holds at every edge out of reset
`define TIW_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("trie core check failed");
// antecedent implies consequent in the same cycle
`define TIW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trie core check failed");
// antecedent implies consequent in the next cycle
`define TIW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trie core check failed");
`else
`define TIW_ASSERT(lbl, clk, rst, expr)
`define TIW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TIW_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/tiw_pkg.sv
// Shared constants for the prefix trie core: default sizes, operation codes
// and field widths. Depends on nothing.
`default_nettype none

package tiw_pkg;

   localparam int unsigned NODES_DEFAULT    = 1024;
   localparam int unsigned ALPHABET_DEFAULT = 26;

   // operation codes carried on req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FOLLOW = 1'b1;

   localparam int unsigned LETTER_W  = 5;
   localparam int unsigned NODE_IDX_W = 10;
   // wide enough to hold the largest alphabet size for the range compare
   localparam int unsigned ALPHA_CMP_W = 9;

endpackage

`default_nettype wire

>>> hw/rtl/trie_insert_and_walk_core.sv
// Prefix trie walker: one letter per request word, child table in one
// synchronous memory. Depends on tiw_pkg and trie_insert_and_walk_core_assert.svh.
//
//   channel | dir | tdata (low bit first)                          | tuser     | tlast
//   req_    | in  | letter[4:0], zero pad to 8                     | operation | last_of_word
//   rsp_    | out | found, word_end, node_index[9:0], pool_full,   | -         | -
//           |     | zero pad to 16                                 |           |
//
// A request's child slot is read from the memory's read port in the accept
// cycle, then checked and written back through the write port in ST_LOOK.
// After reset all NODES*ALPHABET child table entries (26624 at default sizes)
// are swept to zero, with req_tready low.
// A result waiting in the output register holds the next request in ST_LOOK
// until rsp_tready takes it.
`default_nettype none
`include "trie_insert_and_walk_core_assert.svh"

module trie_insert_and_walk_core #(
   parameter int unsigned NODES    = tiw_pkg::NODES_DEFAULT,
   parameter int unsigned ALPHABET = tiw_pkg::ALPHABET_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [4:0] letter
   input  wire logic [0:0]  req_tuser,  // [0] operation
   input  wire logic        req_tlast,  // last_of_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // [0] found, [1] word_end,
                                        // [11:2] node_index, [12] pool_full
);
   import tiw_pkg::*;

   localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int unsigned DEPTH = NODES * ALPHABET;
   localparam int unsigned AW    = $clog2(DEPTH);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   // entry: [NW] word end of the child, [NW-1:0] child node (0 = none)
   logic [NW:0]    mem [DEPTH];
   logic [NW:0]    rd_data_ff;

   logic [1:0]     state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff;
   logic [NW-1:0]  cursor_ff, cursor_in;
   logic [NW:0]    next_free_ff, next_free_in;

   logic           op_ff, last_ff, ok_ff;
   logic [AW-1:0]  slot_ff;

   logic           rsp_valid_ff;
   logic           found_ff, wend_ff, full_ff;
   logic [NODE_IDX_W-1:0] node_ff;

   logic [LETTER_W-1:0] letter;
   logic           letter_ok;
   logic [AW-1:0]  slot_in;
   logic           req_fire, mem_re;
   logic           look_go;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [NW:0]    mem_wdata;

   logic [NW-1:0]  child;
   logic           found_in, wend_in, full_in;
   logic [NW-1:0]  node_in;
   logic           lk_we;
   logic [NW:0]    lk_wdata;
   logic [NW+NODE_IDX_W-1:0] node_wide;

   assign letter    = req_tdata[LETTER_W-1:0];
   assign letter_ok = ALPHA_CMP_W'(letter) < ALPHA_CMP_W'(ALPHABET);
   assign slot_in   = AW'(AW'(cursor_ff) * AW'(ALPHABET)) + AW'(letter);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign mem_re     = req_fire && letter_ok;
   assign look_go    = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_tready);

   // resolve the slot read in the accept cycle
   always_comb begin
      child     = rd_data_ff[NW-1:0];
      found_in  = 1'b0;
      wend_in   = 1'b0;
      full_in   = 1'b0;
      node_in   = '0;
      lk_we     = 1'b0;
      lk_wdata  = rd_data_ff;
      next_free_in = next_free_ff;
      if (ok_ff) begin
         if (child == '0) begin
            if (op_ff == OP_INSERT) begin
               if (next_free_ff < (NW+1)'(NODES)) begin
                  // allocate the next free node and link it
                  found_in     = 1'b1;
                  node_in      = next_free_ff[NW-1:0];
                  wend_in      = last_ff;
                  lk_we        = 1'b1;
                  lk_wdata     = {last_ff, next_free_ff[NW-1:0]};
                  next_free_in = next_free_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
         end else begin
            found_in = 1'b1;
            node_in  = child;
            if (op_ff == OP_INSERT && last_ff) begin
               wend_in  = 1'b1;
               lk_we    = 1'b1;
               lk_wdata = {1'b1, child};
            end else begin
               wend_in = rd_data_ff[NW];
            end
         end
      end
      cursor_in = (found_in && !last_ff) ? node_in : '0;
   end

   assign node_wide = (NW+NODE_IDX_W)'(node_in);

   // clear sweep and look-up write-back share the write port
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = look_go && lk_we;
         mem_waddr = slot_ff;
         mem_wdata = lk_wdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (look_go) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cursor_ff    <= '0;
         next_free_ff <= (NW+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (look_go) begin
            cursor_ff    <= cursor_in;
            next_free_ff <= next_free_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tuser[0];
         last_ff <= req_tlast;
         ok_ff   <= letter_ok;
         slot_ff <= slot_in;
      end
      if (look_go) begin
         found_ff <= found_in;
         wend_ff  <= wend_in;
         full_ff  <= full_in;
         node_ff  <= node_wide[NODE_IDX_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, full_ff, node_ff, wend_ff, found_ff};

   `TIW_ASSERT(a_free_bound, clock, reset, next_free_ff <= (NW+1)'(NODES))
   `TIW_ASSERT_IMP(a_full_no_hit, clock, reset, rsp_valid_ff, !(full_ff && found_ff))
   `TIW_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !found_ff, node_ff == '0 && !wend_ff)
   `TIW_ASSERT_NXT(a_accept_look, clock, reset, req_fire, state_ff == ST_LOOK)
   `TIW_ASSERT_IMP(a_cursor_root, clock, reset, state_ff == ST_CLEAR, cursor_ff == '0)

endmodule

`default_nettype wire
